FILE: rtl/fas_pkg.sv
// Shared types, codes and defaults for the frame animation sequencer.
// No dependencies; every other file of the block refers to this package.
package fas_pkg;

  // Default values for the top-level parameters
  localparam int MAX_FRAMES_DEF = 256;
  localparam int TIME_BITS_DEF  = 32;

  // Fixed field widths
  localparam int REQ_W      = 2;
  localparam int NOW_W      = 32;
  localparam int DELTA_W    = 16;
  localparam int FRAME_W    = 8;
  localparam int MODE_W     = 2;
  localparam int INTERVAL_W = 16;
  localparam int COOL_W     = 16;
  localparam int COUNT_W    = 9;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PLAY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PAUSE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd3;

  // Run modes
  localparam logic [MODE_W-1:0] MODE_PLAY     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAUSE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COOLDOWN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ENDED    = 2'd3;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_LOOPING  = 2'd1;
  localparam logic [1:0] REG_COOLDOWN = 2'd2;
  localparam logic [1:0] REG_COUNT    = 2'd3;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd100;
  localparam logic [COOL_W-1:0]     COOLDOWN_RST = 16'd0;
  localparam logic [COUNT_W-1:0]    COUNT_RST    = 9'd1;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: rtl/fas_channels.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on fas_pkg for field widths.
interface fas_req_if;
  logic                           valid;
  logic                           ready;
  logic [fas_pkg::REQ_W-1:0]      req_type;
  logic [fas_pkg::NOW_W-1:0]      now_ms;
  logic [fas_pkg::DELTA_W-1:0]    delta_ms;
  logic [fas_pkg::FRAME_W-1:0]    frame_index;

  modport source (output valid, req_type, now_ms, delta_ms, frame_index, input ready);
  modport sink   (input valid, req_type, now_ms, delta_ms, frame_index, output ready);
endinterface

interface fas_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fas_pkg::FRAME_W-1:0]    current_frame;
  logic [fas_pkg::MODE_W-1:0]     mode;

  modport source (output valid, current_frame, mode, input ready);
  modport sink   (input valid, current_frame, mode, output ready);
endinterface

FILE: rtl/fas_divider.sv
// Bit-serial restoring divider: accumulator by frame interval, one quotient bit a cycle.
// Depends on fas_pkg for the interval width and the status struct.
module fas_divider #(
  parameter int TIME_BITS = fas_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [TIME_BITS-1:0]            dividend,
  input  logic [fas_pkg::INTERVAL_W-1:0]  divisor,
  output logic [TIME_BITS-1:0]            quotient,
  output fas_pkg::div_status_t            status
);

  localparam int CNT_W = $clog2(TIME_BITS + 1);
  localparam int DV_W  = fas_pkg::INTERVAL_W;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS-1:0] quo_r, quo_nxt;
  logic [DV_W-1:0]      rem_r, rem_nxt;
  logic [DV_W:0]        trial;
  logic [DV_W:0]        diff;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, quo_r[TIME_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(TIME_BITS);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      quo_nxt  = {quo_r[TIME_BITS-2:0], fits};
      rem_nxt  = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Advance the datapath shift registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = (cnt_r != '0);
  assign status.done = done_r;

endmodule

FILE: rtl/frame_animation_sequencer_core.sv
// Frame animation sequencer: one response per request, one request in work at a time.
// Each request passes from idle through execute to write, where the response is loaded into
// the output register once it is free; a tick in play mode goes through the bit-serial
// divider and a frame-step state between execute and write. A new request is accepted
// while the previous response waits in the output register.
// Synchronous active-low reset clears the control and sequencer state and restores the register defaults.
module frame_animation_sequencer_core #(
  parameter int MAX_FRAMES = fas_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = fas_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fas_req_if.sink                           in_ch,
  fas_rsp_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fas_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [fas_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [fas_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int FW  = fas_pkg::FRAME_W;
  localparam int CW  = fas_pkg::COUNT_W;
  localparam int MW  = fas_pkg::MODE_W;
  localparam int NW  = fas_pkg::NOW_W;
  localparam int CAP = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam logic [CW-1:0] CAP_N = CW'(CAP);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  logic [2:0]                         state_r, state_nxt;

  // Configuration registers
  logic [fas_pkg::INTERVAL_W-1:0]     interval_r;
  logic                               looping_r;
  logic [fas_pkg::COOL_W-1:0]         cooldown_r;
  logic [CW-1:0]                      count_r;

  // Sequencer state
  logic [MW-1:0]                      mode_r, mode_nxt;
  logic [FW-1:0]                      pos_r, pos_nxt;
  logic [TIME_BITS-1:0]               acc_r, acc_nxt;
  logic [NW-1:0]                      deadline_r, deadline_nxt;
  logic                               was_set_r, was_set_nxt;

  // Latched request
  logic [fas_pkg::REQ_W-1:0]          req_r;
  logic [NW-1:0]                      now_r;
  logic [fas_pkg::DELTA_W-1:0]        delta_r;
  logic [FW-1:0]                      idx_r;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic [FW-1:0]                      out_frame_r;
  logic [MW-1:0]                      out_mode_r;

  // Datapath helpers
  logic                               wr_en;
  logic [CW-1:0]                      cnt_nz;
  logic [CW-1:0]                      total;
  logic [FW-1:0]                      last;
  logic [TIME_BITS:0]                 sum_ext;
  logic [TIME_BITS-1:0]               sum_sat;
  logic [NW-1:0]                      since;
  logic [fas_pkg::INTERVAL_W-1:0]     divisor;
  logic                               div_start;
  logic [TIME_BITS-1:0]               quo;
  fas_pkg::div_status_t               div_st;
  logic                               q_big;
  logic [CW:0]                        reach;
  logic                               out_free;

  // Configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= fas_pkg::INTERVAL_RST;
      looping_r  <= 1'b0;
      cooldown_r <= fas_pkg::COOLDOWN_RST;
      count_r    <= fas_pkg::COUNT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        fas_pkg::REG_INTERVAL: interval_r <= pwdata[fas_pkg::INTERVAL_W-1:0];
        fas_pkg::REG_LOOPING:  looping_r  <= pwdata[0];
        fas_pkg::REG_COOLDOWN: cooldown_r <= pwdata[fas_pkg::COOL_W-1:0];
        fas_pkg::REG_COUNT:    count_r    <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fas_pkg::REG_INTERVAL: prdata = {16'd0, interval_r};
      fas_pkg::REG_LOOPING:  prdata = {31'd0, looping_r};
      fas_pkg::REG_COOLDOWN: prdata = {16'd0, cooldown_r};
      fas_pkg::REG_COUNT:    prdata = {23'd0, count_r};
      default:               prdata = '0;
    endcase
  end

  // Effective frame count and last frame
  assign cnt_nz = (count_r == '0) ? CW'(1) : count_r;
  assign total  = (cnt_nz > CAP_N) ? CAP_N : cnt_nz;
  assign last   = FW'(total - CW'(1));

  // Saturating accumulator sum
  assign sum_ext = (TIME_BITS+1)'(acc_r) + (TIME_BITS+1)'(delta_r);
  assign sum_sat = sum_ext[TIME_BITS] ? '1 : sum_ext[TIME_BITS-1:0];

  // Wrap-safe deadline test
  assign since = now_r - deadline_r;

  assign divisor   = (interval_r == '0) ? fas_pkg::INTERVAL_W'(1) : interval_r;
  assign div_start = (state_r == ST_EXEC) && (req_r == fas_pkg::REQ_TICK) &&
                     (mode_r == fas_pkg::MODE_PLAY);

  fas_divider #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_sat),
    .divisor  (divisor),
    .quotient (quo),
    .status   (div_st)
  );

  // Frame step compare on the registered quotient
  assign q_big = (|quo[TIME_BITS-1:CW]) || (quo[CW-1:0] >= total);
  assign reach = (CW+1)'(pos_r) + (CW+1)'(quo[CW-1:0]);

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Sequencer next state
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    deadline_nxt = deadline_r;
    was_set_nxt  = was_set_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_WRITE;
        case (req_r)
          fas_pkg::REQ_TICK: begin
            if (mode_r == fas_pkg::MODE_PLAY) begin
              acc_nxt   = sum_sat;
              state_nxt = ST_DIV;
            end else if (mode_r == fas_pkg::MODE_COOLDOWN && !since[NW-1]) begin
              if (!was_set_r) pos_nxt = '0;
              was_set_nxt = 1'b0;
              mode_nxt    = fas_pkg::MODE_PLAY;
            end
          end
          fas_pkg::REQ_PLAY: begin
            if (mode_r == fas_pkg::MODE_ENDED || mode_r == fas_pkg::MODE_COOLDOWN) begin
              if (!was_set_r) pos_nxt = '0;
              was_set_nxt = 1'b0;
            end
            mode_nxt = fas_pkg::MODE_PLAY;
          end
          fas_pkg::REQ_PAUSE: begin
            if (mode_r == fas_pkg::MODE_PLAY || mode_r == fas_pkg::MODE_COOLDOWN)
              mode_nxt = fas_pkg::MODE_PAUSE;
          end
          fas_pkg::REQ_SET: begin
            pos_nxt = (idx_r > last) ? last : idx_r;
            if (mode_r == fas_pkg::MODE_ENDED || mode_r == fas_pkg::MODE_COOLDOWN)
              was_set_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_st.done) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        state_nxt = ST_WRITE;
        if (quo != '0) begin
          acc_nxt = '0;
          if (q_big || reach >= (CW+1)'(total)) begin
            if (looping_r) begin
              deadline_nxt = now_r + NW'(cooldown_r);
              mode_nxt     = fas_pkg::MODE_COOLDOWN;
            end else begin
              mode_nxt = fas_pkg::MODE_ENDED;
            end
            pos_nxt = last;
          end else begin
            pos_nxt = pos_r + quo[FW-1:0];
          end
        end
      end
      ST_WRITE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drop the response once taken, load it when the slot frees
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (state_r == ST_WRITE && out_free) out_valid_nxt = 1'b1;
  end

  // Control and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= fas_pkg::MODE_PAUSE;
      pos_r       <= '0;
      acc_r       <= '0;
      deadline_r  <= '0;
      was_set_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      deadline_r  <= deadline_nxt;
      was_set_r   <= was_set_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request payload and the response payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r   <= in_ch.req_type;
      now_r   <= in_ch.now_ms;
      delta_r <= in_ch.delta_ms;
      idx_r   <= in_ch.frame_index;
    end
    if (state_r == ST_WRITE && out_free) begin
      out_frame_r <= pos_r;
      out_mode_r  <= mode_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.current_frame = out_frame_r;
  assign out_ch.mode          = out_mode_r;

  // Checks
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_EXEC)
    else $error("accepted transaction did not enter execution");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_set_flag_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(was_set_r) |-> $past(req_r) == fas_pkg::REQ_SET)
    else $error("frame-set flag raised by a request other than set frame");

  a_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("response not loaded on write");

endmodule
